[sv/stwdc_pkg.sv]
// shared constants and types for the stereo table waveshaper with dc blocker
`timescale 1ns / 1ps
`default_nettype none

package stwdc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int GAIN_W     = 16;
    localparam int NWORD      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_GAIN  = 3'd0,
        CFG_POST_GAIN = 3'd1,
        CFG_DC_POLE   = 3'd2,
        CFG_TABLE_0   = 3'd3,
        CFG_TABLE_1   = 3'd4,
        CFG_TABLE_2   = 3'd5,
        CFG_TABLE_3   = 3'd6
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] PRE_GAIN_RST  = 16'd4096;
    localparam logic [GAIN_W-1:0] POST_GAIN_RST = 16'd4096;
    localparam logic [GAIN_W-1:0] DC_POLE_RST   = 16'd65253;

    // interpolation datapath
    localparam int STEP_W   = 16;
    localparam int Y_W      = 17;
    localparam int H_W      = 22;
    localparam int MU_W     = 15;
    localparam int Q15      = 15;
    localparam int DC_SHIFT = 16;
    localparam int MUL_B_W  = 17;

    localparam logic signed [Y_W-1:0] ONE_Q15 = 17'sd32768;

endpackage

`default_nettype wire

[sv/stwdc_mul.sv]
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module stwdc_mul #(
    parameter int A_W = 25,
    parameter int B_W = 17
) (
    input  logic                        i_clk,
    input  logic signed [A_W-1:0]       i_a,
    input  logic signed [B_W-1:0]       i_b,
    output logic signed [A_W+B_W-1:0]   o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

[sv/stereo_table_waveshaper_dc_block_top.sv]
// top level of the stereo table waveshaper with dc blocker
`timescale 1ns / 1ps
`default_nettype none

// Each stereo item passes through both channels one after the other on a single
// shared multiplier driven by a small sequencer: per channel one product for the
// table position, four table reads, three Horner products, one post gain product
// and one dc blocker product. Once both results sit in the output register, the
// input is ready again; it is not ready while an item is in work, so no new item
// is taken before the last is through. The output register holds a finished
// result until it is taken, while the next item is accepted; a second finished item
// waits, with the input not ready, until the output register is free. Configuration
// writes are taken every cycle and must only come while the block is idle.
module stereo_table_waveshaper_dc_block_top #(
    parameter  int SAMPLE_WIDTH = stwdc_pkg::SAMPLE_WIDTH_DEF,
    localparam int DATA_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [DATA_W-1:0]                  s_axis_tdata,  // left_sample, right_sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [DATA_W-1:0]                  m_axis_tdata,  // left_result, right_result
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stwdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stwdc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import stwdc_pkg::*;

    localparam int W       = SAMPLE_WIDTH;
    localparam int MA_W    = (W + 1 > H_W) ? W + 1 : H_W;
    localparam int P_W     = MA_W + MUL_B_W;
    localparam int SH_POST = 28 - W;

    localparam logic signed [P_W:0] RND_H    = (P_W + 1)'(1) << (Q15 - 1);
    localparam logic signed [P_W:0] RND_POST = (P_W + 1)'(1) << (SH_POST - 1);
    localparam logic signed [P_W:0] RND_DC   = (P_W + 1)'(1) << (DC_SHIFT - 1);
    localparam logic signed [P_W:0] SAT_HI   = (P_W + 1)'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [P_W:0] SAT_LO   = ~SAT_HI;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MPOS,
        ST_IDX,
        ST_FETCH,
        ST_COEF,
        ST_MH,
        ST_ACC,
        ST_MPOST,
        ST_SATX,
        ST_MDC,
        ST_DC,
        ST_OUT
    } t_state;

    // configuration registers
    logic [GAIN_W-1:0]     r_pre_gain;
    logic [GAIN_W-1:0]     r_post_gain;
    logic [GAIN_W-1:0]     r_dc_pole;
    logic [CFG_DATA_W-1:0] r_tab [NWORD];

    // sequencer and datapath registers
    t_state                r_state;
    logic                  r_ch;
    logic [1:0]            r_pt;
    logic [1:0]            r_step;
    logic signed [W-1:0]   r_smp [2];
    logic signed [W-1:0]   r_res [2];
    logic signed [W-1:0]   r_prev_in [2];
    logic signed [W-1:0]   r_prev_out [2];
    logic signed [W-1:0]   r_x;
    logic [4:0]            r_idx;
    logic [MU_W-1:0]       r_mu;
    logic signed [Y_W-1:0] r_y [4];
    logic signed [H_W-1:0] r_h;
    logic signed [H_W-1:0] r_a1;
    logic signed [H_W-1:0] r_a2;
    logic                  r_m_valid;
    logic [DATA_W-1:0]     r_m_data;

    // combinational next values and helpers
    logic signed [W-1:0]     smp;
    logic [W-1:0]            u;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [P_W-1:0]   prod;
    logic signed [P_W:0]     prod_x;
    logic [4:0]              n_idx;
    logic [MU_W-1:0]         n_mu;
    logic signed [5:0]       k;
    logic [CFG_DATA_W-1:0]   tab_word;
    logic [STEP_W-1:0]       lane;
    logic signed [Y_W-1:0]   n_point;
    logic signed [H_W-1:0]   y0, y1, y2, y3;
    logic signed [H_W-1:0]   n_a0, n_a1, n_a2;
    logic signed [H_W-1:0]   addend;
    logic signed [P_W:0]     hsum;
    logic signed [H_W-1:0]   n_h;
    logic signed [P_W:0]     psum;
    logic signed [P_W:0]     pshift;
    logic signed [P_W:0]     dsum_r;
    logic signed [P_W:0]     dround;
    logic signed [P_W:0]     dsum;
    logic signed [P_W:0]     sat_in;
    logic signed [W-1:0]     sat_out;

    // configuration write port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_gain  <= PRE_GAIN_RST;
            r_post_gain <= POST_GAIN_RST;
            r_dc_pole   <= DC_POLE_RST;
            for (int i = 0; i < NWORD; i++) begin
                r_tab[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRE_GAIN:  r_pre_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_POST_GAIN: r_post_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DC_POLE:   r_dc_pole   <= i_cfg_data[GAIN_W-1:0];
                CFG_TABLE_0:   r_tab[0]    <= i_cfg_data;
                CFG_TABLE_1:   r_tab[1]    <= i_cfg_data;
                CFG_TABLE_2:   r_tab[2]    <= i_cfg_data;
                CFG_TABLE_3:   r_tab[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand selection for the shared multiplier
    assign smp = r_smp[r_ch];
    assign u   = {~smp[W-1], smp[W-2:0]};

    always_comb begin
        case (r_state)
            ST_MPOS: begin
                mul_a = $signed(MA_W'(u));
                mul_b = $signed(MUL_B_W'(r_pre_gain));
            end
            ST_MH: begin
                mul_a = MA_W'(r_h);
                mul_b = $signed(MUL_B_W'(r_mu));
            end
            ST_MPOST: begin
                mul_a = MA_W'(r_h);
                mul_b = $signed(MUL_B_W'(r_post_gain));
            end
            default: begin
                mul_a = MA_W'(r_prev_out[r_ch]);
                mul_b = $signed(MUL_B_W'(r_dc_pole));
            end
        endcase
    end

    stwdc_mul #(
        .A_W (MA_W),
        .B_W (MUL_B_W)
    ) u_stwdc_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign prod_x = (P_W + 1)'(prod);

    // table position, saturating at the end of the table
    always_comb begin
        if (|prod[W+15:W+12]) begin
            n_idx = 5'd16;
            n_mu  = '0;
        end else begin
            n_idx = {1'b0, prod[W+11:W+8]};
            n_mu  = prod[W+7:W-7];
        end
    end

    // table point read, below the table reads zero, above reads one
    assign k        = $signed({1'b0, r_idx}) + $signed({4'b0000, r_pt}) - 6'sd1;
    assign tab_word = r_tab[k[3:2]];
    assign lane     = tab_word[{k[1:0], 4'b0000} +: STEP_W];

    always_comb begin
        if (k[5]) begin
            n_point = '0;
        end else if (k[4]) begin
            n_point = ONE_Q15;
        end else begin
            n_point = Y_W'($signed(lane));
        end
    end

    // cubic coefficients
    assign y0   = H_W'(r_y[0]);
    assign y1   = H_W'(r_y[1]);
    assign y2   = H_W'(r_y[2]);
    assign y3   = H_W'(r_y[3]);
    assign n_a0 = y3 - y2 - y0 + y1;
    assign n_a1 = y0 + y0 - y1 - y1 - y3 + y2;
    assign n_a2 = y2 - y0;

    // horner step
    always_comb begin
        case (r_step)
            2'd0:    addend = r_a1;
            2'd1:    addend = r_a2;
            default: addend = y1;
        endcase
    end

    assign hsum = prod_x + ((P_W + 1)'(addend) <<< Q15) + RND_H;
    assign n_h  = hsum[Q15 +: H_W];

    // post gain and dc blocker sums
    assign psum   = prod_x + RND_POST;
    assign pshift = psum >>> SH_POST;
    assign dsum_r = prod_x + RND_DC;
    assign dround = dsum_r >>> DC_SHIFT;
    assign dsum   = (P_W + 1)'(r_x) - (P_W + 1)'(r_prev_in[r_ch]) + dround;

    // shared saturation
    assign sat_in = (r_state == ST_DC) ? dsum : pshift;

    always_comb begin
        if (sat_in > SAT_HI) begin
            sat_out = SAT_HI[W-1:0];
        end else if (sat_in < SAT_LO) begin
            sat_out = SAT_LO[W-1:0];
        end else begin
            sat_out = sat_in[W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ch      <= 1'b0;
            r_pt      <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_prev_in[i]  <= '0;
                r_prev_out[i] <= '0;
            end
        end else begin
            if (m_axis_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_smp[0] <= $signed(s_axis_tdata[W-1:0]);
                        r_smp[1] <= $signed(s_axis_tdata[2*W-1:W]);
                        r_ch     <= 1'b0;
                        r_state  <= ST_MPOS;
                    end
                end
                ST_MPOS: begin
                    r_state <= ST_IDX;
                end
                ST_IDX: begin
                    r_idx   <= n_idx;
                    r_mu    <= n_mu;
                    r_pt    <= '0;
                    r_state <= ST_FETCH;
                end
                ST_FETCH: begin
                    r_y[r_pt] <= n_point;
                    r_pt      <= r_pt + 2'd1;
                    if (r_pt == 2'd3) begin
                        r_state <= ST_COEF;
                    end
                end
                ST_COEF: begin
                    r_h     <= n_a0;
                    r_a1    <= n_a1;
                    r_a2    <= n_a2;
                    r_step  <= '0;
                    r_state <= ST_MH;
                end
                ST_MH: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_h <= n_h;
                    if (r_step == 2'd2) begin
                        r_state <= ST_MPOST;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= ST_MH;
                    end
                end
                ST_MPOST: begin
                    r_state <= ST_SATX;
                end
                ST_SATX: begin
                    r_x     <= sat_out;
                    r_state <= ST_MDC;
                end
                ST_MDC: begin
                    r_state <= ST_DC;
                end
                ST_DC: begin
                    r_prev_in[r_ch]  <= r_x;
                    r_prev_out[r_ch] <= sat_out;
                    r_res[r_ch]      <= sat_out;
                    if (r_ch) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_ch    <= 1'b1;
                        r_state <= ST_MPOS;
                    end
                end
                ST_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= DATA_W'({r_res[1], r_res[0]});
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

[sv/stwdc_checker.sv]
// port-level checks for the stereo table waveshaper with dc blocker
`timescale 1ns / 1ps
`default_nettype none

module stwdc_checker #(
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // reset leaves the block ready for an item
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // an accepted item keeps the input closed while it is in work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // a result never rises in the cycle after an item is accepted
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result too early");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind stereo_table_waveshaper_dc_block_top stwdc_checker #(
    .DATA_W (DATA_W)
) u_stwdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/stereo_table_waveshaper_dc_block_top_tb.sv]
// self-checking testbench: directed table then random stereo items, checked by a shaping predictor
`timescale 1ns / 1ps

module stereo_table_waveshaper_dc_block_top_tb;
    import stwdc_pkg::*;

    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int DW = ((2 * SW + 7) / 8) * 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic [SW-1:0] S_MIN = 16'h8000;
    localparam logic [SW-1:0] S_MAX = 16'h7FFF;
    localparam longint STEP_ONE = 32768;
    localparam int NSTEP = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int EPOCH_ITEMS = 145;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DW-1:0]         s_axis_tdata = '0;  // left_sample, right_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DW-1:0]         m_axis_tdata;       // left_result, right_result
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SW-1:0]         left;
        logic [SW-1:0]         right;
        logic                  typed;
        logic [SW-1:0]         exp_left;
        logic [SW-1:0]         exp_right;
    } t_row;

    t_row          rows[$];
    logic [DW-1:0] shaped_q[$];
    logic [DW-1:0] want_pair;
    int            err_cnt = 0;
    int            stall_cnt = 0;
    int            src_pct = 0;
    int            snk_pct = 0;

    // predictor state
    longint      pre_g, post_g, pole;
    logic [63:0] tbl_word[NWORD];
    longint      pin_l, pout_l, pin_r, pout_r;

    stereo_table_waveshaper_dc_block_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void predictor_reset();
        pre_g = PRE_GAIN_RST;
        post_g = POST_GAIN_RST;
        pole = DC_POLE_RST;
        for (int w = 0; w < NWORD; w++) tbl_word[w] = '0;
        pin_l = 0;
        pout_l = 0;
        pin_r = 0;
        pout_r = 0;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_PRE_GAIN:  pre_g = longint'(d[GAIN_W-1:0]);
            CFG_POST_GAIN: post_g = longint'(d[GAIN_W-1:0]);
            CFG_DC_POLE:   pole = longint'(d[GAIN_W-1:0]);
            CFG_TABLE_0:   tbl_word[0] = d;
            CFG_TABLE_1:   tbl_word[1] = d;
            CFG_TABLE_2:   tbl_word[2] = d;
            CFG_TABLE_3:   tbl_word[3] = d;
            default: ;
        endcase
    endfunction

    function automatic longint rnd_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint sat_sample(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // points off the low end read zero, off the high end read one
    function automatic longint step_val(longint k);
        logic signed [STEP_W-1:0] st;
        if (k < 0) return 0;
        if (k >= NSTEP) return STEP_ONE;
        st = tbl_word[k / 4][(k % 4) * 16 +: 16];
        return longint'(st);
    endfunction

    function automatic longint shape_channel(logic [SW-1:0] raw);
        longint u, p, idx, mu, y0, y1, y2, y3, a0, a1, a2, h;
        u = longint'($signed(raw)) + 32768;
        p = u * pre_g;
        idx = p >>> (SW + 8);
        mu = (p >>> (SW - 7)) & 64'h7FFF;
        if (idx >= NSTEP) begin
            idx = NSTEP;
            mu = 0;
        end
        y0 = step_val(idx - 1);
        y1 = step_val(idx);
        y2 = step_val(idx + 1);
        y3 = step_val(idx + 2);
        a0 = y3 - y2 - y0 + y1;
        a1 = y0 - y1 - a0;
        a2 = y2 - y0;
        h = a0;
        h = rnd_shift(h * mu + a1 * STEP_ONE, Q15);
        h = rnd_shift(h * mu + a2 * STEP_ONE, Q15);
        h = rnd_shift(h * mu + y1 * STEP_ONE, Q15);
        return sat_sample(rnd_shift(h * post_g, 28 - SW));
    endfunction

    function automatic longint dc_stage(longint x, longint px, longint py);
        return sat_sample(x - px + rnd_shift(pole * py, DC_SHIFT));
    endfunction

    function automatic logic [DW-1:0] predict_pair(logic [SW-1:0] l, logic [SW-1:0] r);
        longint xl, xr, yl, yr;
        xl = shape_channel(l);
        yl = dc_stage(xl, pin_l, pout_l);
        pin_l = xl;
        pout_l = yl;
        xr = shape_channel(r);
        yr = dc_stage(xr, pin_r, pout_r);
        pin_r = xr;
        pout_r = yr;
        return {yr[SW-1:0], yl[SW-1:0]};
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        t_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = d;
        rows.push_back(row);
    endfunction

    function automatic void add_item(logic [SW-1:0] l, logic [SW-1:0] r);
        t_row row;
        row = '0;
        row.left = l;
        row.right = r;
        rows.push_back(row);
    endfunction

    function automatic void add_typed(logic [SW-1:0] l, logic [SW-1:0] r,
                                      logic [SW-1:0] el, logic [SW-1:0] er);
        t_row row;
        row = '0;
        row.left = l;
        row.right = r;
        row.typed = 1'b1;
        row.exp_left = el;
        row.exp_right = er;
        rows.push_back(row);
    endfunction

    function automatic void build_table();
        // zero table at reset: lowest sample sits on step zero
        add_typed(S_MIN, S_MIN, 16'h0000, 16'h0000);
        add_typed(S_MIN, S_MIN, 16'h0000, 16'h0000);
        // upper gain bits dropped; position saturates past the end, reads one
        add_cfg(CFG_PRE_GAIN, 64'hFFFF_FFFF_FFFF_FFFF);
        add_typed(S_MAX, S_MAX, S_MAX, S_MAX);
        // out of range index is ignored
        add_cfg(CFG_IDX_SPARE, 64'h0123_4567_89AB_CDEF);
        add_cfg(CFG_TABLE_0, 64'h8000_7FFF_0000_4000);
        add_cfg(CFG_TABLE_1, 64'hC000_2000_E000_1000);
        add_cfg(CFG_TABLE_2, 64'h1234_F00D_5A5A_A5A5);
        add_cfg(CFG_TABLE_3, 64'h7FFF_7FFF_8000_8000);
        add_cfg(CFG_PRE_GAIN, 64'h0000_0000_0000_1000);
        add_item(16'h0000, 16'h0000);
        add_item(16'hFFFF, 16'h0001);
        add_item(S_MAX, S_MIN);
        add_item(16'h4000, 16'hC000);
        add_item(S_MIN, S_MAX);
        add_item(16'h0800, 16'hF7FF);
        add_cfg(CFG_POST_GAIN, 64'h0000_0000_0000_FFFF);
        add_item(16'h2345, 16'hDCBA);
        add_item(S_MAX, S_MAX);
        add_item(16'h1000, 16'hE000);
        add_cfg(CFG_DC_POLE, 64'h0);
        add_item(16'h5555, 16'hAAAA);
        add_item(16'h0000, S_MIN);
        add_cfg(CFG_DC_POLE, 64'h0000_0000_0000_FFFF);
        add_item(16'h7000, 16'h9000);
        add_item(16'h3C3C, 16'hC3C3);
        add_cfg(CFG_POST_GAIN, 64'h0);
        add_item(16'h6000, 16'hA000);
        add_item(16'h0101, 16'hFEFE);
        add_cfg(CFG_PRE_GAIN, 64'hFFFF_FFFF_FFFF_0000);
        add_item(S_MAX, S_MIN);
        add_item(16'h1357, 16'hECA8);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(int lo, int hi);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(1) == 0) begin
                w[i * 16 +: 16] = 16'($urandom);
            end else begin
                w[i * 16 +: 16] = 16'($urandom_range(16383) - 8192);
            end
        end
        return w;
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(15))
            0: return S_MIN;
            1: return S_MAX;
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic send_pair(logic [SW-1:0] l, logic [SW-1:0] r,
                             logic typed, logic [DW-1:0] typed_pair);
        logic [DW-1:0] pred;
        @(negedge i_clk);
        while ($urandom_range(99) < src_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r, l};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = predict_pair(l, r);
        shaped_q.push_back(typed ? typed_pair : pred);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (shaped_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_cfg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        cfg_write(CFG_PRE_GAIN, {$urandom, 16'($urandom), pick_gain(2048, 8191)});
        cfg_write(CFG_POST_GAIN, {$urandom, 16'($urandom), pick_gain(0, 8191)});
        cfg_write(CFG_DC_POLE, {$urandom, 16'($urandom), pick_gain(60000, 65535)});
        cfg_write(CFG_TABLE_0, rand_word());
        cfg_write(CFG_TABLE_1, rand_word());
        cfg_write(CFG_TABLE_2, rand_word());
        cfg_write(CFG_TABLE_3, rand_word());
        if ($urandom_range(3) == 0) cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (shaped_q.size() == 0) begin
                $error("result with nothing pending: %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want_pair = shaped_q.pop_front();
                if (m_axis_tdata[SW-1:0] !== want_pair[SW-1:0]) begin
                    $error("left_result: expected %0d, got %0d",
                           $signed(want_pair[SW-1:0]), $signed(m_axis_tdata[SW-1:0]));
                    err_cnt++;
                end
                if (m_axis_tdata[2*SW-1:SW] !== want_pair[2*SW-1:SW]) begin
                    $error("right_result: expected %0d, got %0d",
                           $signed(want_pair[2*SW-1:SW]), $signed(m_axis_tdata[2*SW-1:SW]));
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        t_row row;
        predictor_reset();
        build_table();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_pct = 22;
        snk_pct = 46;
        foreach (rows[k]) begin
            row = rows[k];
            if (row.is_cfg) begin
                drain();
                cfg_write(row.idx, row.data);
            end else begin
                send_pair(row.left, row.right, row.typed, {row.exp_right, row.exp_left});
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_pct = 22;
                    snk_pct = 46;
                end
                1: begin
                    src_pct = 46;
                    snk_pct = 22;
                end
                default: begin
                    src_pct = 0;
                    snk_pct = 0;
                end
            endcase
            for (int ep = 0; ep < 4; ep++) begin
                drain();
                random_config();
                repeat (EPOCH_ITEMS) send_pair(rand_sample(), rand_sample(), 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
